[design/v3mu_pkg.sv]
// ----------------------------------------------------------------------------
// v3mu_pkg
// Shared types, command and error codes and the saturation helper of the
// three-component vector unit.
// ----------------------------------------------------------------------------
package v3mu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int FIELD_BITS    = 32;
	localparam int EPS_BITS      = 16;
	localparam int CMD_BITS      = 4;
	localparam int SQRT_STAGES   = 32;
	localparam int WIDE_BITS     = 72;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ADD       = 4'd0,
		CMD_SUB       = 4'd1,
		CMD_MUL       = 4'd2,
		CMD_DIV       = 4'd3,
		CMD_SCALE     = 4'd4,
		CMD_ADDSCALAR = 4'd5,
		CMD_NEG       = 4'd6,
		CMD_DOT       = 4'd7,
		CMD_CROSS     = 4'd8,
		CMD_NORM      = 4'd9,
		CMD_NORMALIZE = 4'd10,
		CMD_COMPARE   = 4'd11
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_DIV_ZERO = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_t;

	typedef logic signed [WIDE_BITS-1:0] wide_t;

	typedef struct packed {
		logic                  ovf;
		logic [FIELD_BITS-1:0] val;
	} sat_t;

	// per-item results known once the lanes and the merge stage are done
	typedef struct packed {
		logic [CMD_BITS-1:0]        cmd;
		logic [2:0][FIELD_BITS-1:0] r;
		logic [FIELD_BITS-1:0]      sc;
		logic                       ovf;
		logic                       same;
	} early_t;

	// clamp to a signed range of rb bits, flag when clamped
	function automatic sat_t sat_q(input wide_t v, input int rb);
		wide_t hi;
		wide_t lo;
		sat_t  res;
		hi = (wide_t'(1) <<< (rb - 1)) - wide_t'(1);
		lo = -hi - wide_t'(1);
		if (v > hi) begin
			res = {1'b1, hi[FIELD_BITS-1:0]};
		end else if (v < lo) begin
			res = {1'b1, lo[FIELD_BITS-1:0]};
		end else begin
			res = {1'b0, v[FIELD_BITS-1:0]};
		end
		return res;
	endfunction

endpackage

[design/v3mu_req_if.sv]
// ----------------------------------------------------------------------------
// v3mu_req_if
// Request channel: command, two vectors and a scalar.
// ----------------------------------------------------------------------------
interface v3mu_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic signed [31:0] ax;
	logic signed [31:0] ay;
	logic signed [31:0] az;
	logic signed [31:0] bx;
	logic signed [31:0] by;
	logic signed [31:0] bz;
	logic signed [31:0] scalar_in;

	modport source(output valid, command, ax, ay, az, bx, by, bz, scalar_in,
		input ready);
	modport sink(input valid, command, ax, ay, az, bx, by, bz, scalar_in,
		output ready);
endinterface

[design/v3mu_rsp_if.sv]
// ----------------------------------------------------------------------------
// v3mu_rsp_if
// Response channel: result vector, scalar, compare flag and error code.
// ----------------------------------------------------------------------------
interface v3mu_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] rx;
	logic signed [31:0] ry;
	logic signed [31:0] rz;
	logic signed [31:0] scalar_out;
	logic        same_flag;
	logic [1:0]  error_code;

	modport source(output valid, rx, ry, rz, scalar_out, same_flag, error_code,
		input ready);
	modport sink(input valid, rx, ry, rz, scalar_out, same_flag, error_code,
		output ready);
endinterface

[design/vector3_math_unit.sv]
// ----------------------------------------------------------------------------
// vector3_math_unit
// Three-component signed fixed-point vector unit with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command with vectors a, b and a scalar per beat; rsp
//   returns one result beat per request beat, in order. Both channels move
//   a beat when valid and ready are high at a rising edge of clk.
//   epsilon is written through cfg_we/cfg_wdata while the unit is idle.
// Path: every command (Q16.16 by default) goes from request beat to result
//   valid through the lane multipliers and the merge stage, the square root
//   pipeline and the divider pipeline, then the output register.
// Throughput: one beat per cycle while no result is held; three lanes and
//   dividers run side by side, and all commands flow through the same stages.
// Reset: arst_n clears all valid bits at once and sets epsilon to 7; no
//   beat is in flight afterwards.
// Stall: while a result waits with ready low the whole pipeline holds and
//   req.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vector3_math_unit #(
	parameter int FRAC_BITS = v3mu_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = v3mu_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	v3mu_req_if.sink                        req,
	v3mu_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [v3mu_pkg::EPS_BITS-1:0]   cfg_wdata
);

	localparam int RES_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam int SQ       = v3mu_pkg::SQRT_STAGES;
	localparam int DV       = 32 + FRAC_BITS;
	localparam int TOT      = 2 + SQ + DV;
	localparam logic [31:0] SAT_HI = 32'((64'sd1 <<< (RES_BITS - 1)) - 64'sd1);
	localparam logic [31:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic [2:0][31:0] a;
		logic [2:0][31:0] b;
	} opnd_t;

	typedef struct packed {
		v3mu_pkg::early_t e;
		logic [31:0]      root;
	} late_t;

	logic                          adv;
	logic [TOT-1:0]                vld_q;
	logic                          out_vld_q;
	logic [v3mu_pkg::EPS_BITS-1:0] eps_q;
	logic [v3mu_pkg::CMD_BITS-1:0] cmd_s1;
	logic [v3mu_pkg::CMD_BITS-1:0] cmd_s2;

	logic signed [31:0]  av [3];
	logic signed [31:0]  bv [3];
	logic signed [63:0]  pm [3];
	logic signed [31:0]  a2 [3];
	logic signed [31:0]  b2 [3];
	v3mu_pkg::sat_t      lres [3];
	logic [2:0]          near;
	logic [63:0]         sumsq_s2;
	v3mu_pkg::early_t    early;
	opnd_t               opnd;
	opnd_t               opnd_q [SQ];
	v3mu_pkg::early_t    early_q [SQ];
	late_t               late_q [DV];
	logic [31:0]         root;

	logic [DV-1:0]       quo [3];
	logic [2:0]          dv_neg;
	logic [2:0]          dv_dz;
	logic [2:0]          dv_pos;
	logic [2:0]          dv_nneg;

	v3mu_pkg::early_t    fe;
	logic [2:0][31:0]    fr;
	logic [31:0]         fsc;
	logic                fsame;
	logic                dz_any;
	logic                ovf_any;
	v3mu_pkg::sat_t      st;
	v3mu_pkg::wide_t     qs;
	v3mu_pkg::err_t      ferr;

	logic signed [31:0]  rx_q;
	logic signed [31:0]  ry_q;
	logic signed [31:0]  rz_q;
	logic signed [31:0]  sc_q;
	logic                same_q;
	logic [1:0]          err_q;

	// whole pipeline advances unless a result is held at the output
	assign adv       = !out_vld_q || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= v3mu_pkg::EPS_BITS'(7);
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[TOT-2:0], req.valid};
			out_vld_q <= vld_q[TOT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= req.command;
			cmd_s2 <= cmd_s1;
		end
	end

	assign av[0] = req.ax;
	assign av[1] = req.ay;
	assign av[2] = req.az;
	assign bv[0] = req.bx;
	assign bv[1] = req.by;
	assign bv[2] = req.bz;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int J1 = (i + 1) % 3;
		localparam int J2 = (i + 2) % 3;
		v3mu_lane #(
			.FRAC_BITS(FRAC_BITS),
			.RES_BITS (RES_BITS)
		) u_lane (
			.clk    (clk),
			.en     (adv),
			.cmd    (req.command),
			.cmd_s1 (cmd_s1),
			.a      (av[i]),
			.b      (bv[i]),
			.s      (req.scalar_in),
			.xa1    (av[J1]),
			.xb2    (bv[J2]),
			.xa2    (av[J2]),
			.xb1    (bv[J1]),
			.eps    (eps_q),
			.pm_s1  (pm[i]),
			.a_s2   (a2[i]),
			.b_s2   (b2[i]),
			.res_s2 (lres[i]),
			.near_s2(near[i])
		);
		assign opnd.a[i] = a2[i];
		assign opnd.b[i] = b2[i];
	end

	v3mu_merge #(
		.FRAC_BITS(FRAC_BITS),
		.RES_BITS (RES_BITS)
	) u_merge (
		.clk     (clk),
		.en      (adv),
		.cmd_s1  (cmd_s1),
		.cmd_s2  (cmd_s2),
		.pm      (pm),
		.res     (lres),
		.near    (near),
		.sumsq_s2(sumsq_s2),
		.early   (early)
	);

	v3mu_sqrt u_sqrt (
		.clk (clk),
		.en  (adv),
		.rad (sumsq_s2),
		.root(root)
	);

	// carry operands and early results alongside the root stages
	always_ff @(posedge clk) begin
		if (adv) begin
			opnd_q[0]  <= opnd;
			early_q[0] <= early;
			for (int k = 1; k < SQ; k++) begin
				opnd_q[k]  <= opnd_q[k-1];
				early_q[k] <= early_q[k-1];
			end
			late_q[0] <= {early_q[SQ-1], root};
			for (int k = 1; k < DV; k++) begin
				late_q[k] <= late_q[k-1];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		logic signed [32:0] den;
		assign den = (early_q[SQ-1].cmd == v3mu_pkg::CMD_DIV)
			? 33'($signed(opnd_q[SQ-1].b[i])) : {1'b0, root};
		v3mu_div #(
			.FRAC_BITS(FRAC_BITS)
		) u_div (
			.clk    (clk),
			.en     (adv),
			.num    ($signed(opnd_q[SQ-1].a[i])),
			.den    (den),
			.quo    (quo[i]),
			.neg    (dv_neg[i]),
			.dz     (dv_dz[i]),
			.num_pos(dv_pos[i]),
			.num_neg(dv_nneg[i])
		);
	end

	always_comb begin
		fe      = late_q[DV-1].e;
		fr      = fe.r;
		fsc     = fe.sc;
		fsame   = fe.same;
		dz_any  = 1'b0;
		ovf_any = fe.ovf;
		st      = '0;
		qs      = '0;
		case (fe.cmd) inside
			v3mu_pkg::CMD_DIV, v3mu_pkg::CMD_NORMALIZE: begin
				ovf_any = 1'b0;
				for (int i = 0; i < 3; i++) begin
					if (dv_dz[i]) begin
						// zero divisor: clamp by the sign of the numerator
						dz_any = 1'b1;
						fr[i]  = dv_pos[i] ? SAT_HI : (dv_nneg[i] ? SAT_LO : '0);
					end else begin
						qs      = dv_neg[i] ? -v3mu_pkg::wide_t'(quo[i])
							: v3mu_pkg::wide_t'(quo[i]);
						st      = v3mu_pkg::sat_q(qs, RES_BITS);
						fr[i]   = st.val;
						ovf_any = ovf_any | st.ovf;
					end
				end
			end
			v3mu_pkg::CMD_NORM: begin
				st      = v3mu_pkg::sat_q(v3mu_pkg::wide_t'(late_q[DV-1].root), RES_BITS);
				fsc     = st.val;
				ovf_any = st.ovf;
			end
			default: begin
			end
		endcase
		ferr = dz_any ? v3mu_pkg::ERR_DIV_ZERO
			: (ovf_any ? v3mu_pkg::ERR_OVERFLOW : v3mu_pkg::ERR_OK);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_q   <= fr[0];
			ry_q   <= fr[1];
			rz_q   <= fr[2];
			sc_q   <= fsc;
			same_q <= fsame;
			err_q  <= ferr;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.rx         = rx_q;
	assign rsp.ry         = ry_q;
	assign rsp.rz         = rz_q;
	assign rsp.scalar_out = sc_q;
	assign rsp.same_flag  = same_q;
	assign rsp.error_code = err_q;

endmodule

[design/v3mu_lane.sv]
// ----------------------------------------------------------------------------
// v3mu_lane
// One component lane: products in the first stage, componentwise result
// with saturation and the epsilon check in the second.
// ----------------------------------------------------------------------------
module v3mu_lane #(
	parameter int FRAC_BITS = v3mu_pkg::FRAC_BITS_DEF,
	parameter int RES_BITS  = v3mu_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [v3mu_pkg::CMD_BITS-1:0]       cmd,
	input  logic [v3mu_pkg::CMD_BITS-1:0]       cmd_s1,
	input  logic signed [31:0]                  a,
	input  logic signed [31:0]                  b,
	input  logic signed [31:0]                  s,
	input  logic signed [31:0]                  xa1,
	input  logic signed [31:0]                  xb2,
	input  logic signed [31:0]                  xa2,
	input  logic signed [31:0]                  xb1,
	input  logic [v3mu_pkg::EPS_BITS-1:0]       eps,
	output logic signed [63:0]                  pm_s1,
	output logic signed [31:0]                  a_s2,
	output logic signed [31:0]                  b_s2,
	output v3mu_pkg::sat_t                      res_s2,
	output logic                                near_s2
);

	logic signed [31:0] opb;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;
	logic signed [31:0] s_s1;
	logic signed [63:0] px1_s1;
	logic signed [63:0] px2_s1;
	v3mu_pkg::sat_t     res;
	v3mu_pkg::wide_t    diff;
	v3mu_pkg::wide_t    adiff;

	// second multiplier operand: scalar for scale, itself for squares
	always_comb begin
		case (cmd)
			v3mu_pkg::CMD_SCALE:     opb = s;
			v3mu_pkg::CMD_NORM:      opb = a;
			v3mu_pkg::CMD_NORMALIZE: opb = a;
			default:                 opb = b;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a;
			b_s1   <= b;
			s_s1   <= s;
			pm_s1  <= a * opb;
			px1_s1 <= xa1 * xb2;
			px2_s1 <= xa2 * xb1;
		end
	end

	always_comb begin
		diff  = v3mu_pkg::wide_t'(a_s1) - v3mu_pkg::wide_t'(b_s1);
		adiff = (diff < 0) ? -diff : diff;
		case (cmd_s1)
			v3mu_pkg::CMD_ADD:
				res = v3mu_pkg::sat_q(diff + v3mu_pkg::wide_t'(b_s1)
					+ v3mu_pkg::wide_t'(b_s1), RES_BITS);
			v3mu_pkg::CMD_SUB:
				res = v3mu_pkg::sat_q(diff, RES_BITS);
			v3mu_pkg::CMD_MUL, v3mu_pkg::CMD_SCALE:
				res = v3mu_pkg::sat_q(v3mu_pkg::wide_t'(pm_s1 >>> FRAC_BITS), RES_BITS);
			v3mu_pkg::CMD_ADDSCALAR:
				res = v3mu_pkg::sat_q(v3mu_pkg::wide_t'(a_s1) + v3mu_pkg::wide_t'(s_s1),
					RES_BITS);
			v3mu_pkg::CMD_NEG:
				res = v3mu_pkg::sat_q(-v3mu_pkg::wide_t'(a_s1), RES_BITS);
			v3mu_pkg::CMD_CROSS:
				res = v3mu_pkg::sat_q((v3mu_pkg::wide_t'(px1_s1)
					- v3mu_pkg::wide_t'(px2_s1)) >>> FRAC_BITS, RES_BITS);
			default:
				res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			res_s2  <= res;
			near_s2 <= (adiff <= v3mu_pkg::wide_t'(eps));
		end
	end

endmodule

[design/v3mu_merge.sv]
// ----------------------------------------------------------------------------
// v3mu_merge
// Merge stage: dot product and sum of squares over the lane products, and
// the gathering of lane results into one early result.
// ----------------------------------------------------------------------------
module v3mu_merge #(
	parameter int FRAC_BITS = v3mu_pkg::FRAC_BITS_DEF,
	parameter int RES_BITS  = v3mu_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [v3mu_pkg::CMD_BITS-1:0] cmd_s1,
	input  logic [v3mu_pkg::CMD_BITS-1:0] cmd_s2,
	input  logic signed [63:0]            pm [3],
	input  v3mu_pkg::sat_t                res [3],
	input  logic [2:0]                    near,
	output logic [63:0]                   sumsq_s2,
	output v3mu_pkg::early_t              early
);

	v3mu_pkg::wide_t dot_sum;
	v3mu_pkg::sat_t  dot_s2;

	assign dot_sum = v3mu_pkg::wide_t'(pm[0]) + v3mu_pkg::wide_t'(pm[1])
		+ v3mu_pkg::wide_t'(pm[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			// floor once over the exact sum
			dot_s2   <= (cmd_s1 == v3mu_pkg::CMD_DOT)
				? v3mu_pkg::sat_q(dot_sum >>> FRAC_BITS, RES_BITS) : '0;
			sumsq_s2 <= 64'(pm[0]) + 64'(pm[1]) + 64'(pm[2]);
		end
	end

	always_comb begin
		early.cmd  = cmd_s2;
		early.r[0] = res[0].val;
		early.r[1] = res[1].val;
		early.r[2] = res[2].val;
		early.sc   = dot_s2.val;
		early.ovf  = res[0].ovf | res[1].ovf | res[2].ovf | dot_s2.ovf;
		early.same = (cmd_s2 == v3mu_pkg::CMD_COMPARE) && (&near);
	end

endmodule

[design/v3mu_sqrt.sv]
// ----------------------------------------------------------------------------
// v3mu_sqrt
// Pipelined integer square root, one result bit per stage, 64 to 32 bits.
// ----------------------------------------------------------------------------
module v3mu_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	localparam int STAGES = v3mu_pkg::SQRT_STAGES;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sq_stage_t;

	sq_stage_t st_s [STAGES];
	sq_stage_t nx   [STAGES];
	sq_stage_t head;

	function automatic sq_stage_t sq_step(input sq_stage_t p);
		logic [35:0] cur;
		logic [35:0] trial;
		logic        ge;
		sq_stage_t   n;
		cur    = {p.rem, p.rad[63:62]};
		trial  = {2'b00, p.root, 2'b01};
		ge     = (cur >= trial);
		n.rem  = ge ? 34'(cur - trial) : cur[33:0];
		n.root = {p.root[30:0], ge};
		n.rad  = {p.rad[61:0], 2'b00};
		return n;
	endfunction

	always_comb begin
		head.rem  = '0;
		head.root = '0;
		head.rad  = rad;
		nx[0] = sq_step(head);
		for (int k = 1; k < STAGES; k++) begin
			nx[k] = sq_step(st_s[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s <= nx;
		end
	end

	assign root = st_s[STAGES-1].root;

endmodule

[design/v3mu_div.sv]
// ----------------------------------------------------------------------------
// v3mu_div
// Pipelined signed fixed-point divider, (num << FRAC_BITS) / den truncated
// toward zero, one quotient bit per stage on magnitudes.
// ----------------------------------------------------------------------------
module v3mu_div #(
	parameter int FRAC_BITS = v3mu_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [31:0]          num,
	input  logic signed [32:0]          den,
	output logic [32+FRAC_BITS-1:0]     quo,
	output logic                        neg,
	output logic                        dz,
	output logic                        num_pos,
	output logic                        num_neg
);

	localparam int QW = 32 + FRAC_BITS;

	typedef struct packed {
		logic [31:0]   rem;
		logic [QW-1:0] dq;
		logic [31:0]   dv;
		logic          neg;
		logic          dz;
		logic          npos;
		logic          nneg;
	} dv_stage_t;

	dv_stage_t   st_s [QW];
	dv_stage_t   nx   [QW];
	dv_stage_t   head;
	logic [31:0] absn;
	logic [32:0] absd;

	function automatic dv_stage_t dv_step(input dv_stage_t p);
		logic [32:0] cur;
		logic        ge;
		dv_stage_t   n;
		cur   = {p.rem, p.dq[QW-1]};
		ge    = (cur >= {1'b0, p.dv});
		n     = p;
		n.rem = ge ? 32'(cur - {1'b0, p.dv}) : cur[31:0];
		n.dq  = {p.dq[QW-2:0], ge};
		return n;
	endfunction

	always_comb begin
		absn      = num[31] ? (~num + 32'd1) : num;
		absd      = den[32] ? (~den + 33'd1) : den;
		head.rem  = '0;
		head.dq   = {absn, {FRAC_BITS{1'b0}}};
		head.dv   = absd[31:0];
		head.neg  = num[31] ^ den[32];
		head.dz   = (den == '0);
		head.npos = !num[31] && (num != '0);
		head.nneg = num[31];
		nx[0] = dv_step(head);
		for (int k = 1; k < QW; k++) begin
			nx[k] = dv_step(st_s[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s <= nx;
		end
	end

	assign quo     = st_s[QW-1].dq;
	assign neg     = st_s[QW-1].neg;
	assign dz      = st_s[QW-1].dz;
	assign num_pos = st_s[QW-1].npos;
	assign num_neg = st_s[QW-1].nneg;

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-component vector unit. A directed table
// covers the extremes, saturation, division by zero, normalising a zero
// vector, compare limits and an unused command code. Random beats follow
// under several epsilon settings. Every result is checked, in order, against
// the table's expected value or an in-bench Q16.16 model, with random idling
// on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
	import v3mu_pkg::*;

	localparam int          CLK_HALF     = 10;
	localparam int          PIPE_DEPTH   = 82;
	localparam int          PHASE_ITEMS  = 280;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam logic [3:0]  CMD_UNUSED   = 4'd15;
	localparam logic signed [31:0] QMAX  = 32'sh7FFFFFFF;
	localparam logic signed [31:0] QMIN  = 32'sh80000000;
	localparam logic signed [31:0] ONE   = 32'sh00010000;

	typedef logic signed [71:0] acc_t;

	typedef struct {
		logic [3:0]         command;
		logic signed [31:0] ax, ay, az, bx, by, bz, s;
	} vec_req_t;

	typedef struct {
		logic signed [31:0] rx, ry, rz, sc;
		logic               same;
		logic [1:0]         err;
	} vec_rsp_t;

	typedef struct {
		vec_req_t in;
		bit       typed;
		vec_rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [EPS_BITS-1:0] cfg_wdata;

	v3mu_req_if req();
	v3mu_rsp_if rsp();

	vector3_math_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic [15:0] eps_copy = 16'd7;
	vec_rsp_t    pending_results[$];
	int          n_sent, n_checked, n_fail, cycles;
	bit          quiet, hold_req;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// ---- model of the datapath ----
	function automatic logic signed [31:0] clamp32(input acc_t v, inout bit ovf);
		if (v > acc_t'(QMAX)) begin
			ovf = 1'b1;
			return QMAX;
		end
		if (v < acc_t'(QMIN)) begin
			ovf = 1'b1;
			return QMIN;
		end
		return v[31:0];
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned rem, res, b;
		rem = v;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic vec_rsp_t vector_result(input vec_req_t q);
		vec_rsp_t o;
		acc_t a[3], b[3], r[3], t, d;
		longint signed na, nb;
		longint unsigned sq, nrm;
		bit ovf, dz;
		int i;
		o = '{default: '0};
		ovf = 0;
		dz = 0;
		a = '{acc_t'(q.ax), acc_t'(q.ay), acc_t'(q.az)};
		b = '{acc_t'(q.bx), acc_t'(q.by), acc_t'(q.bz)};
		r = '{default: '0};
		case (q.command)
			CMD_ADD:       for (i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], ovf);
			CMD_SUB:       for (i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], ovf);
			CMD_MUL:       for (i = 0; i < 3; i++) r[i] = clamp32((a[i] * b[i]) >>> 16, ovf);
			CMD_SCALE:     for (i = 0; i < 3; i++)
				r[i] = clamp32((a[i] * acc_t'(q.s)) >>> 16, ovf);
			CMD_ADDSCALAR: for (i = 0; i < 3; i++) r[i] = clamp32(a[i] + acc_t'(q.s), ovf);
			CMD_NEG:       for (i = 0; i < 3; i++) r[i] = clamp32(-a[i], ovf);
			CMD_DIV: begin
				for (i = 0; i < 3; i++) begin
					if (b[i] == 0) begin
						dz = 1;
						r[i] = (a[i] > 0) ? acc_t'(QMAX) : (a[i] < 0) ? acc_t'(QMIN) : '0;
					end else begin
						na = longint'(a[i]) * 65536;
						nb = longint'(b[i]);
						r[i] = clamp32(acc_t'(na / nb), ovf);
					end
				end
			end
			CMD_DOT: begin
				t = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
				o.sc = clamp32(t >>> 16, ovf);
			end
			CMD_CROSS: begin
				r[0] = clamp32((a[1] * b[2] - a[2] * b[1]) >>> 16, ovf);
				r[1] = clamp32((a[2] * b[0] - a[0] * b[2]) >>> 16, ovf);
				r[2] = clamp32((a[0] * b[1] - a[1] * b[0]) >>> 16, ovf);
			end
			CMD_NORM, CMD_NORMALIZE: begin
				sq = 0;
				for (i = 0; i < 3; i++) sq += longint'(a[i]) * longint'(a[i]);
				nrm = int_sqrt(sq);
				if (q.command == CMD_NORM) begin
					o.sc = clamp32(acc_t'({1'b0, nrm}), ovf);
				end else if (nrm == 0) begin
					dz = 1;
				end else begin
					for (i = 0; i < 3; i++) begin
						na = longint'(a[i]) * 65536;
						r[i] = clamp32(acc_t'(na / longint'(nrm)), ovf);
					end
				end
			end
			CMD_COMPARE: begin
				o.same = 1'b1;
				for (i = 0; i < 3; i++) begin
					d = a[i] - b[i];
					if (d < 0) d = -d;
					if (d > acc_t'(eps_copy)) o.same = 1'b0;
				end
			end
			default: ;
		endcase
		o.rx = r[0][31:0];
		o.ry = r[1][31:0];
		o.rz = r[2][31:0];
		o.err = dz ? ERR_DIV_ZERO : ovf ? ERR_OVERFLOW : ERR_OK;
		return o;
	endfunction

	// ---- result checker ----
	always @(posedge clk) begin
		vec_rsp_t w;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing outstanding");
				n_fail++;
			end else begin
				w = pending_results.pop_front();
				n_checked++;
				if (rsp.rx !== w.rx) begin
					$error("rx: expected %h, got %h", w.rx, rsp.rx); n_fail++;
				end
				if (rsp.ry !== w.ry) begin
					$error("ry: expected %h, got %h", w.ry, rsp.ry); n_fail++;
				end
				if (rsp.rz !== w.rz) begin
					$error("rz: expected %h, got %h", w.rz, rsp.rz); n_fail++;
				end
				if (rsp.scalar_out !== w.sc) begin
					$error("scalar_out: expected %h, got %h", w.sc, rsp.scalar_out); n_fail++;
				end
				if (rsp.same_flag !== w.same) begin
					$error("same_flag: expected %b, got %b", w.same, rsp.same_flag); n_fail++;
				end
				if (rsp.error_code !== w.err) begin
					$error("error_code: expected %0d, got %0d", w.err, rsp.error_code); n_fail++;
				end
			end
		end
	end

	// ---- receiver: random back-pressure, one long hold-off on request ----
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// ---- sender ----
	task automatic send_beat(input vec_req_t q, input bit typed, input vec_rsp_t want);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.command   <= q.command;
		req.ax        <= q.ax;
		req.ay        <= q.ay;
		req.az        <= q.az;
		req.bx        <= q.bx;
		req.by        <= q.by;
		req.bz        <= q.bz;
		req.scalar_in <= q.s;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_results.push_back(typed ? want : vector_result(q));
		n_sent++;
	endtask

	task automatic write_epsilon(input logic [15:0] v);
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		eps_copy = v;
	endtask

	function automatic logic signed [31:0] any_q();
		logic signed [31:0] e[5];
		e = '{32'sd0, 32'sd1, -32'sd1, QMAX, QMIN};
		case ($urandom_range(0, 5))
			0, 1:    return $urandom;
			2, 3:    return $urandom_range(0, 32'h7FFFF) - 32'sh40000;
			4:       return e[$urandom_range(0, 4)];
			default: return $signed($urandom) >>> $urandom_range(1, 30);
		endcase
	endfunction

	function automatic logic signed [31:0] near(input logic signed [31:0] v);
		int span;
		span = int'(eps_copy) + 2;
		return v + ($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic vec_req_t random_beat();
		vec_req_t q;
		q.command = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 15)
			: $urandom_range(0, 11);
		q.ax = any_q(); q.ay = any_q(); q.az = any_q();
		q.s  = any_q();
		if (q.command == CMD_COMPARE && $urandom_range(0, 3) != 0) begin
			q.bx = near(q.ax); q.by = near(q.ay); q.bz = near(q.az);
		end else begin
			q.bx = any_q(); q.by = any_q(); q.bz = any_q();
		end
		return q;
	endfunction

	dir_row_t directed[];
	logic [15:0] eps_plan[5];

	initial begin
		vec_rsp_t none;
		none = '{default: '0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.command = '0;
		{req.ax, req.ay, req.az, req.bx, req.by, req.bz, req.scalar_in} = '0;
		quiet = 0;
		hold_req = 0;
		directed = '{
			'{'{CMD_ADD, QMAX, 0, -5, 1, 0, 3, 0}, 1,
				'{QMAX, 0, -2, 0, 0, ERR_OVERFLOW}},
			'{'{CMD_SUB, QMIN, 5, 0, 1, 5, 0, 0}, 1,
				'{QMIN, 0, 0, 0, 0, ERR_OVERFLOW}},
			'{'{CMD_MUL, ONE, QMAX, QMIN, ONE, 2 * ONE, QMIN, 0}, 0, none},
			'{'{CMD_MUL, -1, 3, QMAX, 1, 5, QMAX, 0}, 0, none},
			'{'{CMD_DIV, 5, -5, 0, 0, 0, 0, 0}, 1,
				'{QMAX, QMIN, 0, 0, 0, ERR_DIV_ZERO}},
			'{'{CMD_DIV, 3 * ONE, QMIN, 7, ONE, 2, -3, 0}, 0, none},
			'{'{CMD_SCALE, ONE, QMAX, QMIN, 0, 0, 0, QMIN}, 0, none},
			'{'{CMD_ADDSCALAR, QMAX, QMIN, 0, 0, 0, 0, -1}, 0, none},
			'{'{CMD_NEG, QMIN, QMAX, 0, 0, 0, 0, 0}, 1,
				'{QMAX, -QMAX, 0, 0, 0, ERR_OVERFLOW}},
			'{'{CMD_DOT, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 0}, 0, none},
			'{'{CMD_DOT, ONE, 2 * ONE, -ONE, 3, -7, 11, 0}, 0, none},
			'{'{CMD_CROSS, QMAX, QMIN, ONE, QMIN, QMAX, -ONE, 0}, 0, none},
			'{'{CMD_CROSS, ONE, 0, 0, 0, ONE, 0, 0}, 0, none},
			'{'{CMD_NORM, QMIN, QMIN, QMIN, 0, 0, 0, 0}, 0, none},
			'{'{CMD_NORM, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0}, 0, none},
			'{'{CMD_NORMALIZE, 0, 0, 0, 1, 1, 1, 1}, 1,
				'{0, 0, 0, 0, 0, ERR_DIV_ZERO}},
			'{'{CMD_NORMALIZE, 3 * ONE, -4 * ONE, 0, 0, 0, 0, 0}, 0, none},
			'{'{CMD_NORMALIZE, 1, 0, 0, 0, 0, 0, 0}, 0, none},
			'{'{CMD_COMPARE, 100, -100, QMAX, 107, -93, QMAX, 0}, 1,
				'{0, 0, 0, 0, 1, ERR_OK}},
			'{'{CMD_COMPARE, 100, 0, 0, 108, 0, 0, 0}, 1,
				'{0, 0, 0, 0, 0, ERR_OK}},
			'{'{CMD_COMPARE, QMAX, 0, 0, QMIN, 0, 0, 0}, 1,
				'{0, 0, 0, 0, 0, ERR_OK}},
			'{'{CMD_UNUSED, QMAX, QMIN, -1, -1, QMIN, QMAX, QMIN}, 1,
				'{0, 0, 0, 0, 0, ERR_OK}}
		};
		eps_plan = '{16'd0, 16'hFFFF, 16'd7, 16'($urandom), 16'd1};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_beat(directed[i].in, directed[i].typed, directed[i].want);

		foreach (eps_plan[p]) begin
			write_epsilon(eps_plan[p]);
			// compare edges under the new tolerance
			send_beat('{CMD_COMPARE, 0, 0, 0, 32'(eps_plan[p]), 0, 0, 0}, 1,
				'{0, 0, 0, 0, 1, ERR_OK});
			send_beat('{CMD_COMPARE, 0, 0, 0, 0, 0, 32'(eps_plan[p]) + 1, 0}, 1,
				'{0, 0, 0, 0, 0, ERR_OK});
			if (p == 1) hold_req = 1;
			if (p == 4) quiet = 1;
			repeat (PHASE_ITEMS) send_beat(random_beat(), 0, none);
		end
		req.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 20) @(posedge clk);

		$display("%0d beats sent, %0d results checked over five epsilon settings,",
			n_sent, n_checked);
		$display("with random idling on both sides and one long output hold-off");
		if (n_fail == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", n_fail);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[vector3_math_unit.f]
design/v3mu_pkg.sv
design/v3mu_req_if.sv
design/v3mu_rsp_if.sv
design/v3mu_lane.sv
design/v3mu_merge.sv
design/v3mu_sqrt.sv
design/v3mu_div.sv
design/vector3_math_unit.sv
verif/tb.sv
